### design/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is high
`define CTS_ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("check failed");

// same, on the usual clk and rst
`define CTS_ASSERT(lbl, prop) `CTS_ASSERT_CLK(lbl, clk, rst, prop)

`endif

### design/cts_pkg.sv
package cts_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_SORT   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_DISABLED  = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSERT_ENABLE = 2'd2;

  localparam logic [2:0] CM_HOLD  = 3'd0;
  localparam logic [2:0] CM_SORT  = 3'd1;
  localparam logic [2:0] CM_MARK  = 3'd2;
  localparam logic [2:0] CM_PACK  = 3'd3;
  localparam logic [2:0] CM_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic       odd;
    logic       wr;
  } cell_ctl_t;

endpackage

### design/cts_req_if.sv
interface cts_req_if #(
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 64
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] column;
  logic [VALUE_BITS-1:0] entry_value;
  logic                  merge_duplicates;

  modport source (output valid, action, row, column, entry_value, merge_duplicates,
                  input ready);
  modport sink (input valid, action, row, column, entry_value, merge_duplicates,
                output ready);
endinterface

### design/cts_rsp_if.sv
interface cts_rsp_if #(
  parameter int VALUE_BITS = 64,
  parameter int CNT_W      = 7
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [CNT_W-1:0]      entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

### design/cts_cell.sv
module cts_cell import cts_pkg::*; #(
  parameter int INDEX      = 0,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 64,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [COORD_BITS-1:0] key_row,
  input  logic [COORD_BITS-1:0] key_col,
  input  logic [VALUE_BITS-1:0] wval,
  input  logic [COORD_BITS-1:0] l_row,
  input  logic [COORD_BITS-1:0] l_col,
  input  logic [VALUE_BITS-1:0] l_val,
  input  logic                  l_dead,
  input  logic                  l_vld,
  input  logic [COORD_BITS-1:0] r_row,
  input  logic [COORD_BITS-1:0] r_col,
  input  logic [VALUE_BITS-1:0] r_val,
  input  logic                  r_dead,
  input  logic                  r_vld,
  output logic [COORD_BITS-1:0] row,
  output logic [COORD_BITS-1:0] col,
  output logic [VALUE_BITS-1:0] val,
  output logic                  dead,
  output logic                  vld,
  input  logic                  tok_hit_i,
  input  logic [VALUE_BITS-1:0] tok_val_i,
  input  logic [CNT_W-1:0]      tok_cnt_i,
  output logic                  tok_hit,
  output logic [VALUE_BITS-1:0] tok_val,
  output logic [CNT_W-1:0]      tok_cnt
);

  localparam logic PAR = (INDEX % 2) == 1;
  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic is_left;
  logic sort_l, sort_r, pack_l, pack_r, match;

  assign vld     = IDX < count;
  assign is_left = (PAR == ctl.odd);
  // strict compare keeps equal keys in insertion order
  assign sort_l  = vld && r_vld && ({row, col} > {r_row, r_col});
  assign sort_r  = l_vld && vld && ({l_row, l_col} > {row, col});
  assign pack_l  = dead && !r_dead && r_vld;
  assign pack_r  = l_dead && !dead && vld;
  assign match   = vld && (row == key_row) && (col == key_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      dead <= 1'b0;
    end else begin
      unique case (ctl.mode)
        CM_SORT, CM_PACK: begin
          if (is_left && ((ctl.mode == CM_SORT) ? sort_l : pack_l)) begin
            row <= r_row; col <= r_col; val <= r_val; dead <= r_dead;
          end else if (!is_left && ((ctl.mode == CM_SORT) ? sort_r : pack_r)) begin
            row <= l_row; col <= l_col; val <= l_val; dead <= l_dead;
          end
        end
        // an entry followed by one with equal coordinates is superseded
        CM_MARK:  dead <= vld && r_vld && (row == r_row) && (col == r_col);
        CM_CLEAR: dead <= 1'b0;
        default: begin
          if (ctl.wr && (IDX == count)) begin
            row <= key_row; col <= key_col; val <= wval; dead <= 1'b0;
          end
        end
      endcase
    end
  end

  // scan token: latest match wins, live entries are counted
  always_ff @(posedge clk) begin
    tok_hit <= match | tok_hit_i;
    tok_val <= match ? val : tok_val_i;
    tok_cnt <= tok_cnt_i + CNT_W'(vld && !dead);
  end

endmodule

### design/coordinate_triplet_store.sv
// insert and unknown actions: result registered at the accepting edge, one item a cycle while the output is free
// lookup: result set by the scan token walking the row of cells
// sort: sorting pass only; with merge the steps are sort, mark, pack, count scan
// one item is worked on at a time; a finished result waits in the output register
// reset (rst, synchronous) empties the list and restores the register defaults
module coordinate_triplet_store import cts_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS:0]   cfg_data,
  cts_req_if.sink               req,
  cts_rsp_if.source             rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CTR_W = $clog2(CAPACITY);
  localparam logic [CTR_W-1:0] CTR_LAST = CTR_W'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SORT = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_PACK = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]            st;
  logic [CTR_W-1:0]      ctr;
  logic [CNT_W-1:0]      count;
  logic [COORD_BITS:0]   row_count, column_count;
  logic                  insert_enable;
  logic [COORD_BITS-1:0] q_row, q_col;
  logic                  op_lookup, op_merge;
  logic                  o_valid;
  logic [2:0]            o_status;
  logic [VALUE_BITS-1:0] o_value;
  logic [CNT_W-1:0]      o_count;

  logic                  acc, out_free, ins_ok, o_load;
  logic [2:0]            ins_status;
  cell_ctl_t             ctl;
  logic [COORD_BITS-1:0] key_row, key_col;

  logic [COORD_BITS-1:0] c_row [CAPACITY];
  logic [COORD_BITS-1:0] c_col [CAPACITY];
  logic [VALUE_BITS-1:0] c_val [CAPACITY];
  logic                  c_dead [CAPACITY];
  logic                  c_vld [CAPACITY];
  logic                  t_hit [CAPACITY];
  logic [VALUE_BITS-1:0] t_val [CAPACITY];
  logic [CNT_W-1:0]      t_cnt [CAPACITY];

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (st == S_IDLE) && out_free;
  assign acc       = req.valid && req.ready;

  // a result is loaded at once for insert and unknown actions, else when the work ends
  assign o_load = (st == S_IDLE) ?
                  (acc && (req.action != ACT_LOOKUP) && (req.action != ACT_SORT)) :
                  ((st == S_FIN) && out_free);

  always_comb begin
    if (!insert_enable) begin
      ins_status = ST_DISABLED;
    end else if (({1'b0, req.row} >= row_count) || ({1'b0, req.column} >= column_count)) begin
      ins_status = ST_RANGE;
    end else if (count >= CNT_W'(CAPACITY)) begin
      ins_status = ST_FULL;
    end else begin
      ins_status = ST_OK;
    end
  end
  assign ins_ok = (ins_status == ST_OK);

  assign key_row = (st == S_IDLE) ? req.row : q_row;
  assign key_col = (st == S_IDLE) ? req.column : q_col;

  always_comb begin
    ctl.odd = ctr[0];
    ctl.wr  = acc && (req.action == ACT_INSERT) && ins_ok;
    unique case (st)
      S_SORT:  ctl.mode = CM_SORT;
      S_MARK:  ctl.mode = CM_MARK;
      S_PACK:  ctl.mode = CM_PACK;
      S_FIN:   ctl.mode = CM_CLEAR;
      default: ctl.mode = CM_HOLD;
    endcase
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [COORD_BITS-1:0] lr, lc, rr, rc;
      logic [VALUE_BITS-1:0] lv, rv, ti_val;
      logic                  ld, lvd, rd, rvd, ti_hit;
      logic [CNT_W-1:0]      ti_cnt;
      if (i == 0) begin : g_first
        assign lr = '0; assign lc = '0; assign lv = '0; assign ld = 1'b0; assign lvd = 1'b0;
        assign ti_hit = 1'b0; assign ti_val = '0; assign ti_cnt = '0;
      end else begin : g_mid
        assign lr = c_row[i-1]; assign lc = c_col[i-1]; assign lv = c_val[i-1];
        assign ld = c_dead[i-1]; assign lvd = c_vld[i-1];
        assign ti_hit = t_hit[i-1]; assign ti_val = t_val[i-1]; assign ti_cnt = t_cnt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rr = '0; assign rc = '0; assign rv = '0; assign rd = 1'b0; assign rvd = 1'b0;
      end else begin : g_next
        assign rr = c_row[i+1]; assign rc = c_col[i+1]; assign rv = c_val[i+1];
        assign rd = c_dead[i+1]; assign rvd = c_vld[i+1];
      end
      cts_cell #(
        .INDEX(i), .COORD_BITS(COORD_BITS), .VALUE_BITS(VALUE_BITS), .CNT_W(CNT_W)
      ) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .count(count),
        .key_row(key_row), .key_col(key_col), .wval(req.entry_value),
        .l_row(lr), .l_col(lc), .l_val(lv), .l_dead(ld), .l_vld(lvd),
        .r_row(rr), .r_col(rc), .r_val(rv), .r_dead(rd), .r_vld(rvd),
        .row(c_row[i]), .col(c_col[i]), .val(c_val[i]), .dead(c_dead[i]), .vld(c_vld[i]),
        .tok_hit_i(ti_hit), .tok_val_i(ti_val), .tok_cnt_i(ti_cnt),
        .tok_hit(t_hit[i]), .tok_val(t_val[i]), .tok_cnt(t_cnt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      ctr           <= '0;
      count         <= '0;
      row_count     <= (COORD_BITS + 1)'(1) << COORD_BITS;
      column_count  <= (COORD_BITS + 1)'(1) << COORD_BITS;
      insert_enable <= 1'b1;
      op_lookup     <= 1'b0;
      op_merge      <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROW_COUNT:     row_count     <= cfg_data;
          REG_COLUMN_COUNT:  column_count  <= cfg_data;
          REG_INSERT_ENABLE: insert_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (acc) begin
            ctr <= '0;
            unique case (req.action)
              ACT_INSERT: begin
                o_status <= ins_status;
                o_value  <= '0;
                o_count  <= count + CNT_W'(ins_ok);
                if (ins_ok) count <= count + CNT_W'(1);
              end
              ACT_LOOKUP: begin
                q_row     <= req.row;
                q_col     <= req.column;
                op_lookup <= 1'b1;
                op_merge  <= 1'b0;
                st        <= S_SCAN;
              end
              ACT_SORT: begin
                op_lookup <= 1'b0;
                op_merge  <= req.merge_duplicates;
                st        <= S_SORT;
              end
              default: begin
                o_status <= ST_OK;
                o_value  <= '0;
                o_count  <= count;
              end
            endcase
          end
        end
        S_SORT: begin
          if (ctr == CTR_LAST) begin
            ctr <= '0;
            st  <= op_merge ? S_MARK : S_FIN;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_MARK: st <= S_PACK;
        S_PACK: begin
          if (ctr == CTR_LAST) begin
            ctr <= '0;
            st  <= S_SCAN;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_SCAN: begin
          if (ctr == CTR_LAST) begin
            ctr <= '0;
            st  <= S_FIN;
          end else begin
            ctr <= ctr + CTR_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            st <= S_IDLE;
            if (op_lookup) begin
              o_status <= t_hit[CAPACITY-1] ? ST_OK : ST_NOT_FOUND;
              o_value  <= t_hit[CAPACITY-1] ? t_val[CAPACITY-1] : '0;
              o_count  <= count;
            end else begin
              o_status <= ST_OK;
              o_value  <= '0;
              o_count  <= op_merge ? t_cnt[CAPACITY-1] : count;
              if (op_merge) count <= t_cnt[CAPACITY-1];
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.status      = o_status;
  assign rsp.found_value = o_value;
  assign rsp.entry_count = o_count;

endmodule

### design/cts_checker.sv
`include "assert_macros.svh"

module cts_checker import cts_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 64,
  parameter int CNT_W      = 7
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [2:0]            rsp_status,
  input logic [VALUE_BITS-1:0] rsp_found_value,
  input logic [CNT_W-1:0]      rsp_entry_count
);

  // a waiting result is not dropped
  `CTS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
  `CTS_ASSERT(a_count_cap, rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
  `CTS_ASSERT(a_miss_zero, rsp_valid && rsp_status != ST_OK |-> rsp_found_value == '0)
  // no new item is taken while a result waits
  `CTS_ASSERT(a_no_accept_while_blocked, rsp_valid && !rsp_ready |-> !(req_valid && req_ready))

endmodule

bind coordinate_triplet_store cts_checker #(
  .CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .CNT_W($clog2(CAPACITY + 1))
) u_cts_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_found_value(rsp.found_value),
  .rsp_entry_count(rsp.entry_count)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import cts_pkg::*;

  localparam int CAP = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [16:0] DIM_MAX = 17'h10000;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] row;
    logic [15:0] column;
    logic [63:0] entry_value;
    logic        merge_duplicates;
  } triplet_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [6:0]  entry_count;
  } triplet_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  logic req_valid = 1'b0;
  triplet_req_t req_item = '0;
  logic rsp_ready = 1'b0;

  cts_req_if #(.COORD_BITS(16), .VALUE_BITS(64)) req_bus ();
  cts_rsp_if #(.VALUE_BITS(64), .CNT_W(7)) rsp_bus ();

  assign req_bus.valid            = req_valid;
  assign req_bus.action           = req_item.action;
  assign req_bus.row              = req_item.row;
  assign req_bus.column           = req_item.column;
  assign req_bus.entry_value      = req_item.entry_value;
  assign req_bus.merge_duplicates = req_item.merge_duplicates;
  assign rsp_bus.ready            = rsp_ready;

  coordinate_triplet_store #(.CAPACITY(CAP), .COORD_BITS(16), .VALUE_BITS(64)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted contents of the triplet list
  logic [15:0] row_mirror [CAP];
  logic [15:0] col_mirror [CAP];
  logic [63:0] val_mirror [CAP];
  int unsigned entry_total = 0;
  logic [16:0] rows_limit = DIM_MAX;
  logic [16:0] cols_limit = DIM_MAX;
  logic        inserts_on = 1'b1;

  triplet_req_t pending_items[$];
  triplet_rsp_t awaited_results[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 0;
  bit taken = 0;

  function automatic triplet_rsp_t apply_action(triplet_req_t it);
    triplet_rsp_t res;
    logic [31:0] key;
    int j, k;
    logic [15:0] r;
    logic [15:0] c;
    logic [63:0] v;
    res = '0;
    case (it.action)
      ACT_INSERT: begin
        if (!inserts_on) res.status = ST_DISABLED;
        else if ({1'b0, it.row} >= rows_limit || {1'b0, it.column} >= cols_limit)
          res.status = ST_RANGE;
        else if (entry_total >= CAP) res.status = ST_FULL;
        else begin
          row_mirror[entry_total] = it.row;
          col_mirror[entry_total] = it.column;
          val_mirror[entry_total] = it.entry_value;
          entry_total++;
          res.status = ST_OK;
        end
      end
      ACT_LOOKUP: begin
        res.status = ST_NOT_FOUND;
        for (k = int'(entry_total) - 1; k >= 0; k--) begin
          if (row_mirror[k] == it.row && col_mirror[k] == it.column) begin
            res.status = ST_OK;
            res.found_value = val_mirror[k];
            break;
          end
        end
      end
      ACT_SORT: begin
        // stable insertion sort on (row, column)
        for (int i = 1; i < int'(entry_total); i++) begin
          r = row_mirror[i];
          c = col_mirror[i];
          v = val_mirror[i];
          key = {r, c};
          j = i;
          while (j > 0 && {row_mirror[j-1], col_mirror[j-1]} > key) begin
            row_mirror[j] = row_mirror[j-1];
            col_mirror[j] = col_mirror[j-1];
            val_mirror[j] = val_mirror[j-1];
            j--;
          end
          row_mirror[j] = r;
          col_mirror[j] = c;
          val_mirror[j] = v;
        end
        if (it.merge_duplicates && entry_total > 0) begin
          k = 0;
          for (int i = 1; i < int'(entry_total); i++) begin
            if (row_mirror[k] != row_mirror[i] || col_mirror[k] != col_mirror[i]) begin
              k++;
              row_mirror[k] = row_mirror[i];
              col_mirror[k] = col_mirror[i];
            end
            val_mirror[k] = val_mirror[i];
          end
          entry_total = k + 1;
        end
        res.status = ST_OK;
      end
      default: res.status = ST_OK;
    endcase
    res.entry_count = entry_total[6:0];
    return res;
  endfunction

  // accept items, predict, and check results
  always @(posedge clk) begin
    triplet_rsp_t exp_res;
    if (!rst) begin
      if (req_bus.valid && req_bus.ready) begin
        awaited_results.push_back(apply_action(pending_items.pop_front()));
        taken = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (rsp_bus.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, rsp_bus.status);
            errors++;
          end
          if (rsp_bus.found_value !== exp_res.found_value) begin
            $error("found_value: expected %h, got %h", exp_res.found_value,
                   rsp_bus.found_value);
            errors++;
          end
          if (rsp_bus.entry_count !== exp_res.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.entry_count,
                   rsp_bus.entry_count);
            errors++;
          end
        end
      end
    end
  end

  // sender
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !taken) begin
      // hold the offered item until it is taken
    end else if (send_gap > 0) begin
      send_gap--;
      req_valid <= 1'b0;
    end else if (pending_items.size() == 0) begin
      req_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(0, 11);
      req_valid <= 1'b0;
    end else begin
      // the taken item has already left the queue, so the front is the next one
      req_valid <= 1'b1;
      req_item <= pending_items[0];
      taken = 1'b0;
    end
  end

  // receiver, with one long hold-off once a few hundred results are in
  int stall_left = 0;
  bit long_hold_done = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done = 1;
      stall_left = 600;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic triplet_req_t make_item(logic [1:0] act, logic [15:0] r,
                                             logic [15:0] c, logic [63:0] v, logic m);
    triplet_req_t it;
    it.action = act;
    it.row = r;
    it.column = c;
    it.entry_value = v;
    it.merge_duplicates = m;
    return it;
  endfunction

  function automatic logic [15:0] pick_coord(logic [16:0] lim);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 16'($urandom_range(0, 5));
    if (sel < 9 && lim != 0) return 16'($urandom_range(0, int'(lim) - 1));
    return 16'($urandom);
  endfunction

  function automatic triplet_req_t random_item();
    int unsigned sel;
    int unsigned k;
    logic [63:0] v;
    v = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 50)
      return make_item(ACT_INSERT, pick_coord(rows_limit), pick_coord(cols_limit), v,
                       1'($urandom));
    if (sel < 85) begin
      if (entry_total > 0 && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, entry_total - 1);
        return make_item(ACT_LOOKUP, row_mirror[k], col_mirror[k], v, 1'($urandom));
      end
      return make_item(ACT_LOOKUP, pick_coord(rows_limit), pick_coord(cols_limit), v,
                       1'($urandom));
    end
    if (sel < 97)
      return make_item(ACT_SORT, 16'($urandom), 16'($urandom), v,
                       $urandom_range(0, 3) != 0);
    return make_item(ACT_UNUSED, 16'($urandom), 16'($urandom), v, 1'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROW_COUNT:     rows_limit = val;
      REG_COLUMN_COUNT:  cols_limit = val;
      REG_INSERT_ENABLE: inserts_on = val[0];
      default: ;
    endcase
  endtask

  task automatic random_phase(int n, logic [16:0] rl, logic [16:0] cl, logic en);
    write_reg(REG_ROW_COUNT, rl);
    write_reg(REG_COLUMN_COUNT, cl);
    write_reg(REG_INSERT_ENABLE, {16'd0, en});
    // items are generated as the list state evolves, a few at a time
    for (int i = 0; i < n; i++) begin
      while (pending_items.size() > 4) @(posedge clk);
      wait (awaited_results.size() == 0 || pending_items.size() > 0);
      pending_items.push_back(random_item());
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, coordinate extremes, duplicates, every action
    pending_items.push_back(make_item(ACT_SORT, 16'h0, 16'h0, 64'h0, 1'b1));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'h0, 16'h0, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_INSERT, 16'hffff, 16'hffff, '1, 1'b1));
    pending_items.push_back(make_item(ACT_INSERT, 16'h0, 16'h0, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_INSERT, 16'h0, 16'h0, 64'h5, 1'b0));
    pending_items.push_back(make_item(ACT_INSERT, 16'h1, 16'h0, 64'haaaa_5555_aaaa_5555,
                                      1'b0));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'h0, 16'h0, '1, 1'b1));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'hffff, 16'hffff, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'h0, 16'h1, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_UNUSED, 16'hffff, 16'hffff, '1, 1'b1));
    pending_items.push_back(make_item(ACT_SORT, 16'h0, 16'h0, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'h0, 16'h0, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_SORT, 16'h0, 16'h0, 64'h0, 1'b1));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'h0, 16'h0, 64'h0, 1'b0));
    pending_items.push_back(make_item(ACT_LOOKUP, 16'hffff, 16'hffff, 64'h0, 1'b0));
    wait_drained();

    // inserts turned off, out-of-range coordinates must still report disabled
    write_reg(REG_INSERT_ENABLE, 17'd0);
    pending_items.push_back(make_item(ACT_INSERT, 16'h1, 16'h1, 64'h1, 1'b0));
    wait_drained();
    write_reg(REG_ROW_COUNT, 17'd0);
    pending_items.push_back(make_item(ACT_INSERT, 16'h0, 16'h0, 64'h1, 1'b0));
    wait_drained();
    write_reg(REG_INSERT_ENABLE, 17'd1);
    // zero row limit rejects everything
    pending_items.push_back(make_item(ACT_INSERT, 16'h0, 16'h0, 64'h1, 1'b0));
    wait_drained();

    random_phase(350, DIM_MAX, DIM_MAX, 1'b1);
    random_phase(200, 17'd1, 17'd1, 1'b1);
    random_phase(250, 17'd5, 17'd4, 1'b1);
    random_phase(80, 17'd0, DIM_MAX, 1'b1);
    random_phase(80, DIM_MAX, 17'd0, 1'b1);
    random_phase(60, DIM_MAX, DIM_MAX, 1'b0);
    random_phase(150, 17'd3, DIM_MAX, 1'b1);
    quiet = 1;
    random_phase(160, DIM_MAX, DIM_MAX, 1'b1);

    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
